/* hdl/rrfd_pkg.sv */
// Shared constants, register indexes and helper functions for the frame difference block.
package rrfd_pkg;

   // Fixed field widths
   localparam int PIXEL_W  = 8;
   localparam int HW_W     = 4;
   localparam int SCORE_W  = 29;
   localparam int MAG_W    = SCORE_W - 1;
   localparam int SUM_W    = SCORE_W + 1;
   localparam int DIV_W    = PIXEL_W + 1;
   localparam int NORM_W   = 2 * HW_W;
   localparam int CHANNELS = 3;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = HW_W;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_WIDTH       = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_NORMALIZE_ENABLE = 1'b1;

   // Register reset values
   localparam logic [HW_W-1:0] HALF_WIDTH_RESET = 4'd4;
   localparam logic            NORMALIZE_RESET  = 1'b1;

   // Parameter defaults
   localparam int MAX_HALF_WIDTH_DEFAULT = 15;
   localparam int FRACTION_BITS_DEFAULT  = 16;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Saturation bound: 3*(2*max_hw+1)^2 scaled by the fraction, capped at 2^28-1
   function automatic logic [MAG_W-1:0] score_limit(input int unsigned max_hw,
                                                    input int unsigned frac);
      longint unsigned side;
      longint unsigned lim;
      side = 64'(2 * max_hw + 1);
      lim  = (64'd3 * side * side) << frac;
      if (lim > 64'h0FFF_FFFF) begin
         lim = 64'h0FFF_FFFF;
      end
      return lim[MAG_W-1:0];
   endfunction

endpackage

/* hdl/rrfd_front.sv */
// Front part: accepts pixels and forms the three signed relative-change terms bit-serially.
module rrfd_front #(
   parameter int FRACTION_BITS = rrfd_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              push,
   output logic                                              full,
   input  logic [rrfd_pkg::CHANNELS-1:0][rrfd_pkg::PIXEL_W-1:0] prev_pix,
   input  logic [rrfd_pkg::CHANNELS-1:0][rrfd_pkg::PIXEL_W-1:0] cur_pix,
   input  logic                                              window_end,
   output logic                                              q_push,
   input  logic                                              q_full,
   output logic [rrfd_pkg::CHANNELS*(FRACTION_BITS+1):0]     q_data
);

   localparam int TERM_W = FRACTION_BITS + 1;
   localparam int CNT_W  = $clog2(FRACTION_BITS + 1);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DIV  = 2'd1;
   localparam logic [1:0] F_HOLD = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [rrfd_pkg::PIXEL_W-1:0]   rem_ff  [rrfd_pkg::CHANNELS];
   logic [FRACTION_BITS-1:0]       quot_ff [rrfd_pkg::CHANNELS];
   logic [rrfd_pkg::DIV_W-1:0]     div_ff  [rrfd_pkg::CHANNELS];
   logic [rrfd_pkg::CHANNELS-1:0]  neg_ff;
   logic                           end_ff;

   logic [rrfd_pkg::PIXEL_W-1:0]   rem_next  [rrfd_pkg::CHANNELS];
   logic [FRACTION_BITS-1:0]       quot_next [rrfd_pkg::CHANNELS];
   logic [rrfd_pkg::PIXEL_W-1:0]   rem_load  [rrfd_pkg::CHANNELS];
   logic [rrfd_pkg::DIV_W-1:0]     div_load  [rrfd_pkg::CHANNELS];
   logic [rrfd_pkg::CHANNELS-1:0]  neg_load;
   logic [TERM_W-1:0]              term      [rrfd_pkg::CHANNELS];

   logic accept;
   logic div_step;

   // One restoring division step per channel, plus operand setup
   always_comb begin
      logic [rrfd_pkg::DIV_W-1:0] shifted;
      logic                       fits;
      logic [rrfd_pkg::PIXEL_W-1:0] mx;
      for (int i = 0; i < rrfd_pkg::CHANNELS; i++) begin
         shifted      = {rem_ff[i], 1'b0};
         fits         = (shifted >= div_ff[i]);
         rem_next[i]  = fits ? rrfd_pkg::PIXEL_W'(shifted - div_ff[i])
                             : rrfd_pkg::PIXEL_W'(shifted);
         quot_next[i] = {quot_ff[i][FRACTION_BITS-2:0], fits};

         mx           = (prev_pix[i] > cur_pix[i]) ? prev_pix[i] : cur_pix[i];
         rem_load[i]  = (prev_pix[i] > cur_pix[i]) ? (prev_pix[i] - cur_pix[i])
                                                   : (cur_pix[i] - prev_pix[i]);
         div_load[i]  = {1'b0, mx} + rrfd_pkg::DIV_W'(1);
         neg_load[i]  = (prev_pix[i] < cur_pix[i]);

         term[i]      = neg_ff[i] ? (-{1'b0, quot_ff[i]}) : {1'b0, quot_ff[i]};
      end
   end

   // Word handed to the queue: window end flag over the three terms
   assign q_data = {end_ff, term[2], term[1], term[0]};
   assign q_push = (state_ff == F_HOLD) && !q_full;
   assign full   = (state_ff != F_IDLE);
   assign accept = push && (state_ff == F_IDLE);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      div_step = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (push) begin
               count_in = CNT_W'(FRACTION_BITS);
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            div_step = 1'b1;
            count_in = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               state_in = F_HOLD;
            end
         end
         F_HOLD: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Divider datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         end_ff <= window_end;
         neg_ff <= neg_load;
      end
      for (int i = 0; i < rrfd_pkg::CHANNELS; i++) begin
         if (accept) begin
            rem_ff[i]  <= rem_load[i];
            div_ff[i]  <= div_load[i];
            quot_ff[i] <= '0;
         end else if (div_step) begin
            rem_ff[i]  <= rem_next[i];
            quot_ff[i] <= quot_next[i];
         end
      end
   end

endmodule

/* hdl/rrfd_queue.sv */
// Short first-in first-out queue between the front and the back.
module rrfd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = rrfd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/rrfd_back.sv */
// Back part: saturating accumulation, optional normalizing division and the result register.
module rrfd_back #(
   parameter int MAX_HALF_WIDTH = rrfd_pkg::MAX_HALF_WIDTH_DEFAULT,
   parameter int FRACTION_BITS  = rrfd_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          q_empty,
   input  logic [rrfd_pkg::CHANNELS*(FRACTION_BITS+1):0] q_data,
   output logic                                          q_pop,
   input  logic                                          csr_write_enable,
   input  logic [rrfd_pkg::CSR_INDEX_W-1:0]              csr_index,
   input  logic [rrfd_pkg::CSR_DATA_W-1:0]               csr_write_data,
   output logic                                          rsp_empty,
   input  logic                                          rsp_pop,
   output logic signed [rrfd_pkg::SCORE_W-1:0]           rsp_score,
   output logic                                          rsp_divide_error
);

   localparam int TERM_W = FRACTION_BITS + 1;
   localparam int STEP_W = $clog2(rrfd_pkg::MAG_W + 1);
   localparam logic [rrfd_pkg::MAG_W-1:0] LIMIT_MAG =
      rrfd_pkg::score_limit(MAX_HALF_WIDTH, FRACTION_BITS);
   localparam logic signed [rrfd_pkg::SUM_W-1:0] LIMIT_POS = {2'b00, LIMIT_MAG};
   localparam logic signed [rrfd_pkg::SUM_W-1:0] LIMIT_NEG = -LIMIT_POS;

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_ADD  = 2'd1;
   localparam logic [1:0] B_DIV  = 2'd2;

   // Control state
   logic [1:0]                            state_ff, state_in;
   logic [1:0]                            ch_ff, ch_in;
   logic [STEP_W-1:0]                     step_ff, step_in;
   logic signed [rrfd_pkg::SCORE_W-1:0]   acc_ff, acc_in;
   logic                                  out_valid_ff, out_valid_in;
   logic [rrfd_pkg::HW_W-1:0]             half_width_ff;
   logic                                  normalize_ff;

   // Payload
   logic [rrfd_pkg::CHANNELS-1:0][TERM_W-1:0] terms_ff;
   logic                                      end_ff;
   logic [rrfd_pkg::NORM_W-1:0]               rem_ff;
   logic [rrfd_pkg::MAG_W-1:0]                quot_ff;
   logic [rrfd_pkg::NORM_W-1:0]               divisor_ff;
   logic                                      neg_ff;
   logic signed [rrfd_pkg::SCORE_W-1:0]       out_score_ff, out_score_in;
   logic                                      out_err_ff, out_err_in;

   logic                                      q_end;
   logic signed [TERM_W-1:0]                  term_sel;
   logic signed [rrfd_pkg::SUM_W-1:0]         sum_raw, sum_sat;
   logic [rrfd_pkg::MAG_W-1:0]                sum_mag;
   logic [rrfd_pkg::NORM_W-1:0]               hw_sq;
   logic [rrfd_pkg::NORM_W:0]                 shifted;
   logic                                      fits;
   logic [rrfd_pkg::NORM_W-1:0]               rem_next;
   logic [rrfd_pkg::MAG_W-1:0]                quot_next;
   logic signed [rrfd_pkg::SCORE_W-1:0]       quot_signed;
   logic                                      load_terms, start_div, div_step, load_out;

   assign q_end = q_data[rrfd_pkg::CHANNELS*TERM_W];

   // Saturating add of the selected channel term
   always_comb begin
      term_sel = terms_ff[ch_ff];
      sum_raw  = rrfd_pkg::SUM_W'(acc_ff) + rrfd_pkg::SUM_W'(term_sel);
      sum_sat  = sum_raw;
      if (sum_raw > LIMIT_POS) begin
         sum_sat = LIMIT_POS;
      end else if (sum_raw < LIMIT_NEG) begin
         sum_sat = LIMIT_NEG;
      end
      sum_mag = (sum_sat < 0) ? rrfd_pkg::MAG_W'(-sum_sat) : rrfd_pkg::MAG_W'(sum_sat);
   end

   // Normalizing divider: one restoring step a cycle on the magnitude
   always_comb begin
      hw_sq       = rrfd_pkg::NORM_W'(half_width_ff) * rrfd_pkg::NORM_W'(half_width_ff);
      shifted     = {rem_ff, quot_ff[rrfd_pkg::MAG_W-1]};
      fits        = (shifted >= {1'b0, divisor_ff});
      rem_next    = fits ? rrfd_pkg::NORM_W'(shifted - {1'b0, divisor_ff})
                         : rrfd_pkg::NORM_W'(shifted);
      quot_next   = {quot_ff[rrfd_pkg::MAG_W-2:0], fits};
      quot_signed = neg_ff ? (-{1'b0, quot_next}) : {1'b0, quot_next};
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff;
      out_score_in = out_score_ff;
      out_err_in   = out_err_ff;
      load_terms   = 1'b0;
      start_div    = 1'b0;
      div_step     = 1'b0;
      load_out     = 1'b0;
      q_pop        = 1'b0;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         B_IDLE: begin
            // a window end waits until the result register is free
            if (!q_empty && !(q_end && out_valid_ff)) begin
               q_pop      = 1'b1;
               load_terms = 1'b1;
               ch_in      = 2'd0;
               state_in   = B_ADD;
            end
         end
         B_ADD: begin
            acc_in = rrfd_pkg::SCORE_W'(sum_sat);
            if (ch_ff == 2'(rrfd_pkg::CHANNELS - 1)) begin
               state_in = B_IDLE;
               if (end_ff) begin
                  acc_in = '0;
                  if (normalize_ff && (half_width_ff != '0)) begin
                     start_div = 1'b1;
                     step_in   = STEP_W'(rrfd_pkg::MAG_W);
                     state_in  = B_DIV;
                  end else begin
                     // raw sum; error when normalizing with zero half width
                     load_out     = 1'b1;
                     out_valid_in = 1'b1;
                     out_score_in = rrfd_pkg::SCORE_W'(sum_sat);
                     out_err_in   = normalize_ff;
                  end
               end
            end else begin
               ch_in = ch_ff + 2'd1;
            end
         end
         B_DIV: begin
            div_step = 1'b1;
            step_in  = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               load_out     = 1'b1;
               out_valid_in = 1'b1;
               out_score_in = quot_signed;
               out_err_in   = 1'b0;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         ch_ff         <= '0;
         step_ff       <= '0;
         acc_ff        <= '0;
         out_valid_ff  <= 1'b0;
         half_width_ff <= rrfd_pkg::HALF_WIDTH_RESET;
         normalize_ff  <= rrfd_pkg::NORMALIZE_RESET;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         step_ff      <= step_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               rrfd_pkg::REG_HALF_WIDTH:       half_width_ff <= csr_write_data;
               rrfd_pkg::REG_NORMALIZE_ENABLE: normalize_ff  <= csr_write_data[0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (load_terms) begin
         terms_ff <= q_data[rrfd_pkg::CHANNELS*TERM_W-1:0];
         end_ff   <= q_end;
      end
      if (start_div) begin
         rem_ff     <= '0;
         quot_ff    <= sum_mag;
         divisor_ff <= hw_sq;
         neg_ff     <= (sum_sat < 0);
      end else if (div_step) begin
         rem_ff  <= rem_next;
         quot_ff <= quot_next;
      end
      if (load_out) begin
         out_score_ff <= out_score_in;
         out_err_ff   <= out_err_in;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_score        = out_score_ff;
   assign rsp_divide_error = out_err_ff;

endmodule

/* hdl/roi_relative_frame_difference.sv */
// Top level of the region-of-interest relative frame difference block.
//
// Each pushed word is one window pixel (previous and current values of three channels and a
// window end flag). Per channel the signed relative change (prev-cur)/(max(prev,cur)+1) with
// FRACTION_BITS fraction bits is added to a saturating accumulator; the window end word yields
// one result, the sum divided by half_width squared when normalizing (raw sum plus
// divide_error when half_width is zero), and clears the accumulator. The front takes no new
// pixel until its bit-serial channel dividers (one quotient bit per cycle) have handed the
// terms to the queue; a two-word queue decouples it from the back, which does the three
// saturating adds per pixel and a bit-serial normalizing division on a normalized window end.
// The result register holds one finished word while the front takes pixels till the queue fills.
module roi_relative_frame_difference #(
   parameter int MAX_HALF_WIDTH = rrfd_pkg::MAX_HALF_WIDTH_DEFAULT,
   parameter int FRACTION_BITS  = rrfd_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel input
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [rrfd_pkg::PIXEL_W-1:0]        req_prev_ch0,
   input  logic [rrfd_pkg::PIXEL_W-1:0]        req_cur_ch0,
   input  logic [rrfd_pkg::PIXEL_W-1:0]        req_prev_ch1,
   input  logic [rrfd_pkg::PIXEL_W-1:0]        req_cur_ch1,
   input  logic [rrfd_pkg::PIXEL_W-1:0]        req_prev_ch2,
   input  logic [rrfd_pkg::PIXEL_W-1:0]        req_cur_ch2,
   input  logic                                req_window_end,
   // result output
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [rrfd_pkg::SCORE_W-1:0] rsp_score,
   output logic                                rsp_divide_error,
   // configuration
   input  logic                                csr_write_enable,
   input  logic [rrfd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rrfd_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int WORD_W = rrfd_pkg::CHANNELS * (FRACTION_BITS + 1) + 1;

   logic [rrfd_pkg::CHANNELS-1:0][rrfd_pkg::PIXEL_W-1:0] prev_pix;
   logic [rrfd_pkg::CHANNELS-1:0][rrfd_pkg::PIXEL_W-1:0] cur_pix;
   logic              q_push, q_full, q_pop, q_empty;
   logic [WORD_W-1:0] q_push_data, q_pop_data;

   assign prev_pix = {req_prev_ch2, req_prev_ch1, req_prev_ch0};
   assign cur_pix  = {req_cur_ch2, req_cur_ch1, req_cur_ch0};

   // Term generation
   rrfd_front #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .prev_pix   (prev_pix),
      .cur_pix    (cur_pix),
      .window_end (req_window_end),
      .q_push     (q_push),
      .q_full     (q_full),
      .q_data     (q_push_data)
   );

   // Decoupling queue
   rrfd_queue #(
      .WIDTH(WORD_W),
      .DEPTH(rrfd_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   // Accumulation, normalization and result
   rrfd_back #(
      .MAX_HALF_WIDTH(MAX_HALF_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_data           (q_pop_data),
      .q_pop            (q_pop),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_score        (rsp_score),
      .rsp_divide_error (rsp_divide_error)
   );

`ifndef SYNTHESIS
   // front only hands a word over when the queue has room
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("front pushed into a full queue");

   // back only takes a word that is there
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("back popped an empty queue");

   // a shown score stays within the saturation bound
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |->
         ($signed(rsp_score) <=
             $signed({1'b0, rrfd_pkg::score_limit(MAX_HALF_WIDTH, FRACTION_BITS)})) &&
         ($signed(rsp_score) >=
             -$signed({1'b0, rrfd_pkg::score_limit(MAX_HALF_WIDTH, FRACTION_BITS)})))
      else $error("score outside the saturation bound");
`endif

endmodule

/* sim/roi_relative_frame_difference_tb.sv */
// Self-checking testbench for the region-of-interest relative frame difference block.
`timescale 1ns / 1ps

// One window pixel as it is pushed into the block
typedef struct packed {
   logic [rrfd_pkg::CHANNELS-1:0][rrfd_pkg::PIXEL_W-1:0] prev;
   logic [rrfd_pkg::CHANNELS-1:0][rrfd_pkg::PIXEL_W-1:0] cur;
   logic                                                 window_end;
} pixel_word_type;

// One window score as the block should pop it
typedef struct {
   logic signed [rrfd_pkg::SCORE_W-1:0] score;
   logic                                divide_error;
} window_score_type;

// Tracks the window sum and the register copies, and holds the scores still to come
class window_score_tracker;
   longint                      change_sum;
   longint                      sum_limit;
   logic [rrfd_pkg::HW_W-1:0]   half_width;
   logic                        normalize_on;
   window_score_type            due_scores[$];
   int                          mismatches;

   function new();
      longint side;
      side       = 2 * rrfd_pkg::MAX_HALF_WIDTH_DEFAULT + 1;
      sum_limit  = (3 * side * side) << rrfd_pkg::FRACTION_BITS_DEFAULT;
      if (sum_limit > 64'h0FFF_FFFF) begin
         sum_limit = 64'h0FFF_FFFF;
      end
      change_sum   = 0;
      half_width   = rrfd_pkg::HALF_WIDTH_RESET;
      normalize_on = rrfd_pkg::NORMALIZE_RESET;
      mismatches   = 0;
   endfunction

   function void write_register(logic [rrfd_pkg::CSR_INDEX_W-1:0] index,
                                logic [rrfd_pkg::CSR_DATA_W-1:0] data);
      case (index)
         rrfd_pkg::REG_HALF_WIDTH: begin
            half_width = data[rrfd_pkg::HW_W-1:0];
         end
         rrfd_pkg::REG_NORMALIZE_ENABLE: begin
            normalize_on = data[0];
         end
         default: ;
      endcase
   endfunction

   // Signed relative change of one channel, truncated toward zero
   function longint channel_change(logic [rrfd_pkg::PIXEL_W-1:0] p,
                                   logic [rrfd_pkg::PIXEL_W-1:0] c);
      longint pv;
      longint cv;
      longint mag;
      longint quot;
      pv   = p;
      cv   = c;
      mag  = ((pv > cv) ? pv - cv : cv - pv) << rrfd_pkg::FRACTION_BITS_DEFAULT;
      quot = mag / (((pv > cv) ? pv : cv) + 1);
      return (pv >= cv) ? quot : -quot;
   endfunction

   // Accepted pixel: saturating adds, and a score on the window end
   function void note_pixel(pixel_word_type px);
      longint           s;
      window_score_type want;
      for (int k = 0; k < rrfd_pkg::CHANNELS; k++) begin
         s = change_sum + channel_change(px.prev[k], px.cur[k]);
         if (s > sum_limit) begin
            s = sum_limit;
         end
         if (s < -sum_limit) begin
            s = -sum_limit;
         end
         change_sum = s;
      end
      if (!px.window_end) begin
         return;
      end
      s = change_sum;
      want.divide_error = 1'b0;
      if (normalize_on) begin
         if (half_width == 0) begin
            want.divide_error = 1'b1;
         end else begin
            s = s / (longint'(half_width) * longint'(half_width));
         end
      end
      want.score = s[rrfd_pkg::SCORE_W-1:0];
      change_sum = 0;
      due_scores.push_back(want);
   endfunction

   // Popped word against the oldest score due
   function void check_score(logic signed [rrfd_pkg::SCORE_W-1:0] score, logic divide_error);
      window_score_type want;
      if (due_scores.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("unexpected word: score %0d divide_error %0b", score, divide_error);
         end
         return;
      end
      want = due_scores.pop_front();
      if (want.score !== score || want.divide_error !== divide_error) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: expected score %0d divide_error %0b, got score %0d divide_error %0b",
                     want.score, want.divide_error, score, divide_error);
         end
      end
   endfunction

   function int pending();
      return due_scores.size();
   endfunction
endclass

module roi_relative_frame_difference_tb;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 150;
   localparam int PHASE_ITEMS   = 90;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_push;
   logic                                  req_full;
   logic [rrfd_pkg::PIXEL_W-1:0]          req_prev_ch0;
   logic [rrfd_pkg::PIXEL_W-1:0]          req_cur_ch0;
   logic [rrfd_pkg::PIXEL_W-1:0]          req_prev_ch1;
   logic [rrfd_pkg::PIXEL_W-1:0]          req_cur_ch1;
   logic [rrfd_pkg::PIXEL_W-1:0]          req_prev_ch2;
   logic [rrfd_pkg::PIXEL_W-1:0]          req_cur_ch2;
   logic                                  req_window_end;
   logic                                  rsp_empty;
   logic                                  rsp_pop;
   logic signed [rrfd_pkg::SCORE_W-1:0]   rsp_score;
   logic                                  rsp_divide_error;
   logic                                  csr_write_enable;
   logic [rrfd_pkg::CSR_INDEX_W-1:0]      csr_index;
   logic [rrfd_pkg::CSR_DATA_W-1:0]       csr_write_data;

   window_score_tracker scores;
   bit                  idle_on = 1'b1;
   int unsigned         quiet_cycles = 0;
   int                  stall_left = 0;

   roi_relative_frame_difference dut (.*);

   always #10 clock = ~clock;

   // Result side: check popped words, stall in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            scores.check_score(rsp_score, rsp_divide_error);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (idle_on && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(0, 13);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("roi_relative_frame_difference test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Push one pixel word, with an optional idle burst ahead of it
   task automatic send_pixel(input pixel_word_type px);
      int gap;
      if (idle_on && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 14);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push       <= 1'b1;
      req_prev_ch0   <= px.prev[0];
      req_cur_ch0    <= px.cur[0];
      req_prev_ch1   <= px.prev[1];
      req_cur_ch1    <= px.cur[1];
      req_prev_ch2   <= px.prev[2];
      req_cur_ch2    <= px.cur[2];
      req_window_end <= px.window_end;
      @(posedge clock);
      while (req_full) @(posedge clock);
      scores.note_pixel(px);
   endtask

   // Hold off pushing until every score is out; optionally let the block settle
   task automatic drain_scores(input bit settle);
      req_push <= 1'b0;
      while (scores.pending() != 0) @(posedge clock);
      if (settle) begin
         repeat (SETTLE_CYCLES) @(posedge clock);
      end
   endtask

   // Write both registers; the enable word carries random upper bits
   task automatic write_settings(input logic [rrfd_pkg::HW_W-1:0] hw, input logic norm);
      logic [rrfd_pkg::CSR_DATA_W-1:0] norm_data;
      norm_data    = rrfd_pkg::CSR_DATA_W'($urandom);
      norm_data[0] = norm;
      csr_write_enable <= 1'b1;
      csr_index        <= rrfd_pkg::REG_HALF_WIDTH;
      csr_write_data   <= rrfd_pkg::CSR_DATA_W'(hw);
      @(posedge clock);
      scores.write_register(rrfd_pkg::REG_HALF_WIDTH, rrfd_pkg::CSR_DATA_W'(hw));
      csr_index      <= rrfd_pkg::REG_NORMALIZE_ENABLE;
      csr_write_data <= norm_data;
      @(posedge clock);
      scores.write_register(rrfd_pkg::REG_NORMALIZE_ENABLE, norm_data);
      csr_write_enable <= 1'b0;
   endtask

   function automatic pixel_word_type make_pixel(input int p0, input int c0, input int p1,
                                                 input int c1, input int p2, input int c2,
                                                 input bit last);
      pixel_word_type px;
      px.prev[0]    = rrfd_pkg::PIXEL_W'(p0);
      px.cur[0]     = rrfd_pkg::PIXEL_W'(c0);
      px.prev[1]    = rrfd_pkg::PIXEL_W'(p1);
      px.cur[1]     = rrfd_pkg::PIXEL_W'(c1);
      px.prev[2]    = rrfd_pkg::PIXEL_W'(p2);
      px.cur[2]     = rrfd_pkg::PIXEL_W'(c2);
      px.window_end = last;
      return px;
   endfunction

   // Level biased toward the extremes and toward a nearby value
   function automatic logic [rrfd_pkg::PIXEL_W-1:0] pick_level(
      input logic [rrfd_pkg::PIXEL_W-1:0] near);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return near;
         3: return near + rrfd_pkg::PIXEL_W'($urandom_range(0, 2)) - rrfd_pkg::PIXEL_W'(1);
         default: return rrfd_pkg::PIXEL_W'($urandom);
      endcase
   endfunction

   function automatic pixel_word_type random_pixel(input bit last);
      pixel_word_type px;
      for (int k = 0; k < rrfd_pkg::CHANNELS; k++) begin
         px.prev[k] = pick_level(rrfd_pkg::PIXEL_W'($urandom));
         px.cur[k]  = pick_level(px.prev[k]);
      end
      px.window_end = last;
      return px;
   endfunction

   task automatic send_window(input int len);
      for (int i = 0; i < len; i++) begin
         send_pixel(random_pixel(i == len - 1));
      end
   endtask

   // Long window of near full-scale changes that drives the sum into its clamp
   task automatic send_saturating_window(input bit positive);
      pixel_word_type px;
      for (int i = 0; i < 1000; i++) begin
         if (i < 980) begin
            for (int k = 0; k < rrfd_pkg::CHANNELS; k++) begin
               px.prev[k] = positive ? rrfd_pkg::PIXEL_W'($urandom_range(252, 255))
                                     : rrfd_pkg::PIXEL_W'($urandom_range(0, 2));
               px.cur[k]  = positive ? rrfd_pkg::PIXEL_W'($urandom_range(0, 2))
                                     : rrfd_pkg::PIXEL_W'($urandom_range(252, 255));
            end
            px.window_end = 1'b0;
         end else begin
            px = random_pixel(i == 999);
         end
         send_pixel(px);
      end
   endtask

   initial begin
      logic [rrfd_pkg::HW_W-1:0] plan_hw[6];
      logic                      plan_norm[6];
      logic [rrfd_pkg::HW_W-1:0] hw;
      logic                      norm;
      int                        sent;
      int                        len;

      plan_hw   = '{4'd0, 4'd15, 4'd1, 4'd4, 4'd0, 4'd15};
      plan_norm = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
      scores    = new();

      reset            <= 1'b1;
      req_push         <= 1'b0;
      req_prev_ch0     <= '0;
      req_cur_ch0      <= '0;
      req_prev_ch1     <= '0;
      req_cur_ch1      <= '0;
      req_prev_ch2     <= '0;
      req_cur_ch2      <= '0;
      req_window_end   <= 1'b0;
      rsp_pop          <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, equal levels, one-step changes, multi-pixel windows
      send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 1));
      send_pixel(make_pixel(255, 0, 255, 0, 255, 0, 1));
      send_pixel(make_pixel(0, 255, 0, 255, 0, 255, 1));
      send_pixel(make_pixel(255, 255, 0, 0, 128, 128, 1));
      send_pixel(make_pixel(255, 254, 1, 0, 0, 1, 1));
      send_pixel(make_pixel(255, 0, 0, 255, 17, 200, 0));
      send_pixel(make_pixel(200, 17, 255, 0, 0, 0, 0));
      send_pixel(make_pixel(1, 2, 3, 4, 100, 50, 1));
      for (int i = 0; i < 4; i++) begin
         send_pixel(make_pixel(255, 0, 254, 1, 170, 85, 0));
      end
      send_pixel(make_pixel(0, 255, 85, 170, 127, 128, 1));
      drain_scores(1'b1);

      // Clamp at the upper bound, normalized
      write_settings(4'd15, 1'b1);
      send_saturating_window(1'b1);
      drain_scores(1'b1);

      // Random windows under a series of settings; the last phase runs without idling
      for (int phase = 0; phase < 8; phase++) begin
         if (phase < 6) begin
            hw   = plan_hw[phase];
            norm = plan_norm[phase];
         end else begin
            hw   = rrfd_pkg::HW_W'($urandom);
            norm = 1'($urandom);
         end
         write_settings(hw, norm);
         if (phase == 7) begin
            idle_on = 1'b0;
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            send_window(len);
            sent += len;
            if (idle_on && $urandom_range(0, 40) == 0) begin
               drain_scores(1'b0);
            end
         end
         drain_scores(1'b1);
      end

      if (scores.mismatches == 0 && scores.pending() == 0) begin
         $display("roi_relative_frame_difference test passed");
      end else begin
         $display("roi_relative_frame_difference test failed");
      end
      $finish;
   end

endmodule
